/* src/cfr_pkg.sv */
// ----------------------------------------------------------------------------
// cfr_pkg
// shared constants, types and helpers of the control frame receiver
// ----------------------------------------------------------------------------
package cfr_pkg;

    localparam int FRAME_LENGTH = 30;
    localparam int MODE_POS     = FRAME_LENGTH - 3;
    localparam int ID_POS       = FRAME_LENGTH - 2;
    localparam int END_POS      = FRAME_LENGTH - 1;

    localparam int FIELD_WORDS  = 13;
    localparam int MODE_IDX     = 13;
    localparam int ID_IDX       = 14;

    localparam int POS_W        = 5;
    localparam int IDX_W        = 4;
    localparam int VAL_W        = 16;
    localparam int BYTE_W       = 8;

    // two frame slots of sixteen word entries each
    localparam int SLOTS        = 2;
    localparam int RAM_AW       = 1 + IDX_W;
    localparam int RAM_DEPTH    = 1 << RAM_AW;

    localparam logic [BYTE_W-1:0] START_RESET = 8'h25;
    localparam logic [BYTE_W-1:0] END_RESET   = 8'h21;

    localparam logic CFG_START = 1'b0;
    localparam logic CFG_END   = 1'b1;

    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] addr;
        logic [VAL_W-1:0]  data;
    } t_ram_wr;

    // a field whose byte pair reaches the mode position reads as zero
    function automatic logic field_is_void(logic [IDX_W-1:0] idx);
        int k;
        k = int'(idx);
        return (k < FIELD_WORDS) && (k * 2 + 2 >= MODE_POS);
    endfunction

endpackage

/* src/control_frame_receiver.sv */
// ----------------------------------------------------------------------------
// control_frame_receiver
// control frame decoder for a byte stream from a serial link
// ----------------------------------------------------------------------------
// input channel: push with i_rx_byte, taken when push is high and full low.
// bytes are taken one per cycle while full is low. an end byte arms the hunt,
// then a start byte opens a frame; a good frame (last byte equal to the end
// byte) gives fifteen items on the result channel: thirteen big-endian
// fields, the mode byte and the id byte, the id item marked by o_last_word.
// result channel: an item waits while empty is low, and pop takes it.
// the first word is ready once the closing byte has been counted in the slot
// queue and the first RAM read has been registered; words then follow one
// per cycle while pop stays high, read from a word RAM at one read a cycle.
// the RAM holds two frame slots: a frame plays out while the next one is
// collected. full rises only while two good frames wait to be played out
// and clears as soon as the older one has left the RAM.
// reset clears the hunt, the slot queue and the output; start and end bytes
// return to 0x25 and 0x21. configuration writes go through i_cfg_we,
// i_cfg_index (0 start byte, 1 end byte) and i_cfg_data.
// ----------------------------------------------------------------------------
module control_frame_receiver
    import cfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [BYTE_W-1:0] i_cfg_data,
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              empty,
    input  logic              pop,
    output logic [IDX_W-1:0]  o_word_index,
    output logic [VAL_W-1:0]  o_word_value,
    output logic              o_last_word
);

    t_ram_wr           wr;
    logic              commit;
    logic              slots_full;
    logic              re;
    logic [RAM_AW-1:0] raddr;
    logic [VAL_W-1:0]  rdata;

    assign full = slots_full;

    cfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (push && !slots_full),
        .i_rx_byte   (i_rx_byte),
        .o_wr        (wr),
        .o_commit    (commit)
    );

    cfr_ram #(
        .WIDTH (VAL_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr.we),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    cfr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_commit     (commit),
        .i_pop        (pop),
        .i_rdata      (rdata),
        .o_re         (re),
        .o_raddr      (raddr),
        .o_slots_full (slots_full),
        .o_empty      (empty),
        .o_word_index (o_word_index),
        .o_word_value (o_word_value),
        .o_last_word  (o_last_word)
    );

endmodule

/* src/cfr_ram.sv */
// ----------------------------------------------------------------------------
// cfr_ram
// generic single write, single read RAM with registered read data
// ----------------------------------------------------------------------------
module cfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/cfr_front.sv */
// ----------------------------------------------------------------------------
// cfr_front
// hunts for frames, packs bytes into words and commits good frames to a slot
// ----------------------------------------------------------------------------
module cfr_front
    import cfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [BYTE_W-1:0] i_cfg_data,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output t_ram_wr           o_wr,
    output logic              o_commit
);

    logic [BYTE_W-1:0] r_start, r_end;
    logic              r_receiving, n_receiving;
    logic              r_armed, n_armed;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [BYTE_W-1:0] r_hi, n_hi;
    logic              r_wr_slot, n_wr_slot;

    logic              is_end;
    logic [IDX_W-1:0]  wr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= START_RESET;
            r_end       <= END_RESET;
            r_receiving <= 1'b0;
            r_armed     <= 1'b0;
            r_pos       <= '0;
            r_wr_slot   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_START: r_start <= i_cfg_data;
                    CFG_END:   r_end   <= i_cfg_data;
                    default:   ;
                endcase
            end
            r_receiving <= n_receiving;
            r_armed     <= n_armed;
            r_pos       <= n_pos;
            r_wr_slot   <= n_wr_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi <= n_hi;
    end

    assign is_end = (i_rx_byte == r_end);

    always_comb begin
        n_receiving = r_receiving;
        n_armed     = r_armed;
        n_pos       = r_pos;
        n_hi        = r_hi;
        n_wr_slot   = r_wr_slot;
        o_commit    = 1'b0;
        o_wr.we     = 1'b0;
        wr_idx      = r_pos[POS_W-1:1] - IDX_W'(1);
        o_wr.data   = {r_hi, i_rx_byte};

        if (i_accept) begin
            if (!r_receiving) begin
                if (is_end) begin
                    n_armed = 1'b1;
                end
                // equal start and end bytes arm and open in one go
                if (i_rx_byte == r_start && (r_armed || is_end)) begin
                    n_pos       = POS_W'(1);
                    n_receiving = 1'b1;
                    n_armed     = 1'b0;
                end
            end else begin
                if (r_pos[0]) begin
                    n_hi = i_rx_byte;
                end
                if (!r_pos[0] && r_pos < POS_W'(MODE_POS)) begin
                    o_wr.we = 1'b1;
                end
                if (r_pos == POS_W'(MODE_POS)) begin
                    o_wr.we   = 1'b1;
                    wr_idx    = IDX_W'(MODE_IDX);
                    o_wr.data = {{(VAL_W-BYTE_W){1'b0}}, i_rx_byte};
                end
                if (r_pos == POS_W'(ID_POS)) begin
                    o_wr.we   = 1'b1;
                    wr_idx    = IDX_W'(ID_IDX);
                    o_wr.data = {{(VAL_W-BYTE_W){1'b0}}, i_rx_byte};
                end
                if (r_pos == POS_W'(END_POS)) begin
                    n_pos       = '0;
                    n_receiving = 1'b0;
                    if (is_end) begin
                        n_armed   = 1'b1;
                        o_commit  = 1'b1;
                        n_wr_slot = ~r_wr_slot;
                    end
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
        end
        o_wr.addr = {r_wr_slot, wr_idx};
    end

endmodule

/* src/cfr_back.sv */
// ----------------------------------------------------------------------------
// cfr_back
// tracks committed frame slots and plays each one out as fifteen words
// ----------------------------------------------------------------------------
module cfr_back
    import cfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_commit,
    input  logic              i_pop,
    input  logic [VAL_W-1:0]  i_rdata,
    output logic              o_re,
    output logic [RAM_AW-1:0] o_raddr,
    output logic              o_slots_full,
    output logic              o_empty,
    output logic [IDX_W-1:0]  o_word_index,
    output logic [VAL_W-1:0]  o_word_value,
    output logic              o_last_word
);

    logic [1:0]       r_pend, n_pend;
    logic             r_rd_slot, n_rd_slot;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_out_idx;
    logic             r_out_zero;
    logic             r_out_last;

    logic             issue;
    logic             finish;

    assign issue   = (r_pend != 2'd0) && (!r_out_valid || i_pop);
    assign finish  = issue && (r_idx == IDX_W'(ID_IDX));
    assign o_re    = issue;
    assign o_raddr = {r_rd_slot, r_idx};

    always_comb begin
        n_idx       = r_idx;
        n_rd_slot   = r_rd_slot;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end
        if (issue) begin
            n_out_valid = 1'b1;
            n_idx       = r_idx + IDX_W'(1);
        end
        if (finish) begin
            n_idx     = '0;
            n_rd_slot = ~r_rd_slot;
        end
        case ({i_commit, finish})
            2'b10:   n_pend = r_pend + 2'd1;
            2'b01:   n_pend = r_pend - 2'd1;
            default: n_pend = r_pend;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_rd_slot   <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend      <= n_pend;
            r_rd_slot   <= n_rd_slot;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_out_idx  <= r_idx;
            r_out_zero <= field_is_void(r_idx);
            r_out_last <= (r_idx == IDX_W'(ID_IDX));
        end
    end

    assign o_slots_full = (r_pend == 2'(SLOTS));
    assign o_empty      = !r_out_valid;
    assign o_word_index = r_out_idx;
    assign o_word_value = r_out_zero ? '0 : i_rdata;
    assign o_last_word  = r_out_last;

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 2'(SLOTS))
        else $error("pending frame count above slot count");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_W'(ID_IDX))
        else $error("word index past id word");

    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_out_valid && r_out_last && r_out_idx == IDX_W'(ID_IDX)))
        else $error("final word of a frame not marked");

    a_no_overcommit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit |-> (r_pend != 2'(SLOTS)))
        else $error("frame committed with both slots pending");

endmodule

/* bench/control_frame_receiver_test.sv */
// ----------------------------------------------------------------------------
// control_frame_receiver_test
// self-checking bench for the control frame receiver: bytes go in through
// the push side with random gaps, decoded words are taken off the pop side
// with random stalls, and every word is checked against a frame decoder
// kept inside the bench
// ----------------------------------------------------------------------------
module control_frame_receiver_test;

    timeunit 1ns;
    timeprecision 1ps;

    import cfr_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RANDOM_ITEMS  = 60;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        logic             last;
    } t_word;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic              i_cfg_index = 1'b0;
    logic [BYTE_W-1:0] i_cfg_data  = '0;
    logic              push        = 1'b0;
    logic              full;
    logic [BYTE_W-1:0] i_rx_byte   = '0;
    logic              empty;
    logic              pop         = 1'b0;
    logic [IDX_W-1:0]  o_word_index;
    logic [VAL_W-1:0]  o_word_value;
    logic              o_last_word;

    control_frame_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_rx_byte   (i_rx_byte),
        .empty       (empty),
        .pop         (pop),
        .o_word_index(o_word_index),
        .o_word_value(o_word_value),
        .o_last_word (o_last_word)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // decoder state, mirrors the block
    logic [BYTE_W-1:0] frame_mem [FRAME_LENGTH];
    logic [POS_W-1:0]  fill_count = '0;
    logic              in_frame   = 1'b0;
    logic              hunt_armed = 1'b0;
    logic [BYTE_W-1:0] start_b    = START_RESET;
    logic [BYTE_W-1:0] end_b      = END_RESET;

    t_word word_q [$];
    int    errors     = 0;
    int    bytes_sent = 0;
    bit    gaps_on    = 1'b1;
    bit    stalls_on  = 1'b1;
    int    hold_req   = 0;
    int    stall_left = 0;

    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        t_word w;
        int    hi;
        int    lo;
        if (!in_frame) begin
            if (b == end_b) hunt_armed = 1'b1;
            if (b == start_b && hunt_armed) begin
                frame_mem[0] = b;
                fill_count   = POS_W'(1);
                in_frame     = 1'b1;
                hunt_armed   = 1'b0;
            end
            return;
        end
        if (fill_count < FRAME_LENGTH) frame_mem[fill_count] = b;
        fill_count = fill_count + 1'b1;
        if (fill_count >= FRAME_LENGTH) begin
            fill_count = '0;
            in_frame   = 1'b0;
            if (frame_mem[END_POS] == end_b) begin
                hunt_armed = 1'b1;
                for (int k = 0; k < FIELD_WORDS; k++) begin
                    hi     = 2 * k + 1;
                    lo     = 2 * k + 2;
                    w.idx  = IDX_W'(k);
                    // fields that would run into the mode byte read as zero
                    w.val  = (lo < MODE_POS) ? {frame_mem[hi], frame_mem[lo]} : '0;
                    w.last = 1'b0;
                    word_q.push_back(w);
                end
                w.idx  = IDX_W'(MODE_IDX);
                w.val  = {8'h00, frame_mem[MODE_POS]};
                w.last = 1'b0;
                word_q.push_back(w);
                w.idx  = IDX_W'(ID_IDX);
                w.val  = {8'h00, frame_mem[ID_POS]};
                w.last = 1'b1;
                word_q.push_back(w);
            end
        end
    endfunction

    // result side: random stall bursts, plus a long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_req > 0) begin
            hold_req = hold_req - 1;
            pop <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            pop <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n && pop && !empty) begin
            if (word_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, actual index %0d value %h last %b",
                         $time, o_word_index, o_word_value, o_last_word);
            end else begin
                w = word_q.pop_front();
                if (o_word_index !== w.idx) begin
                    errors++;
                    $display("%0t: word_index expected %0d actual %0d",
                             $time, w.idx, o_word_index);
                end
                if (o_word_value !== w.val) begin
                    errors++;
                    $display("%0t: word_value expected %h actual %h",
                             $time, w.val, o_word_value);
                end
                if (o_last_word !== w.last) begin
                    errors++;
                    $display("%0t: last_word expected %b actual %b",
                             $time, w.last, o_last_word);
                end
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        decode_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input bit good);
        logic [BYTE_W-1:0] b;
        send_byte(end_b);
        if (start_b != end_b) send_byte(start_b);
        for (int p = 1; p < END_POS; p++) send_byte(BYTE_W'($urandom_range(0, 255)));
        if (good) begin
            send_byte(end_b);
        end else begin
            do b = BYTE_W'($urandom_range(0, 255)); while (b == end_b);
            send_byte(b);
        end
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        push <= 1'b0;
        while (word_q.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        if (word_q.size() != 0) begin
            errors++;
            $display("%0t: %0d words never arrived, expected index %0d value %h",
                     $time, word_q.size(), word_q[0].idx, word_q[0].val);
            word_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // close any open frame as a bad one, then wait for all words
    task automatic go_idle();
        while (in_frame) send_byte(~end_b);
        wait_drained();
    endtask

    task automatic write_reg(input logic idx, input logic [BYTE_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_START) start_b = val;
        else end_b = val;
    endtask

    task automatic set_bytes(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e);
        go_idle();
        write_reg(CFG_START, s);
        write_reg(CFG_END, e);
    endtask

    // reset values, hunt rules, a good frame with extreme bytes and a bad one
    task automatic test_hunt_and_defaults();
        send_byte(START_RESET);    // start with no end byte seen: ignored
        send_byte(8'h00);
        send_byte(END_RESET);      // arms
        send_byte(8'hFF);          // arming survives ignored bytes
        send_byte(START_RESET);    // opens
        for (int p = 1; p < END_POS; p++) begin
            if (p == 5) send_byte(END_RESET);    // end byte inside data
            else send_byte(p[0] ? 8'hFF : 8'h00);
        end
        send_byte(END_RESET);
        // re-armed by the good frame: start opens at once, frame is bad
        send_byte(START_RESET);
        for (int p = 1; p < FRAME_LENGTH; p++) send_byte(8'hAA);
        send_byte(START_RESET);    // unarmed after a bad frame
        go_idle();
    endtask

    task automatic test_register_settings();
        logic [BYTE_W-1:0] s;
        logic [BYTE_W-1:0] e;
        for (int i = 0; i < 3; i++) begin
            case (i)
                0: begin s = 8'h00; e = 8'hFF; end
                1: begin s = 8'hFF; e = 8'h00; end
                default: begin s = 8'h5A; e = 8'h5A; end   // start equals end
            endcase
            set_bytes(s, e);
            send_frame(1'b1);
        end
    endtask

    task automatic test_random_traffic();
        int target;
        int pick;
        logic [BYTE_W-1:0] s;
        for (int chunk = 0; chunk < 4; chunk++) begin
            s = BYTE_W'($urandom_range(0, 255));
            if (chunk == 0) set_bytes(START_RESET, END_RESET);
            else if (chunk == 1) set_bytes(s, s);
            else set_bytes(s, BYTE_W'($urandom_range(0, 255)));
            target = bytes_sent + RANDOM_ITEMS / 4;
            while (bytes_sent < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    send_frame(1'b1);
                end else if (pick < 82) begin
                    send_frame(1'b0);
                end else begin
                    repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // results held back so two frames fill the word store and full rises
    task automatic test_output_backpressure();
        set_bytes(START_RESET, END_RESET);
        hold_req = 400;
        repeat (3) send_frame(1'b1);
        wait_drained();
    endtask

    task automatic test_no_idle();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_frame(1'b1);
        send_frame(1'b0);
        send_frame(1'b1);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_hunt_and_defaults();
        test_register_settings();
        test_random_traffic();
        test_output_backpressure();
        test_no_idle();
        go_idle();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
